### rtl/core/skq_pkg.sv
// ----------------------------------------------------------------------------
// skq_pkg
// Shared constants and codes for the sorted key queue.
// ----------------------------------------------------------------------------
package skq_pkg;
    localparam int SKQ_CAPACITY     = 16;
    localparam int SKQ_KEY_BITS     = 16;
    localparam int SKQ_PAYLOAD_BITS = 32;
    localparam int OUT_KEY_BITS     = 16;
    localparam int OUT_PAY_BITS     = 32;

    localparam logic [1:0] ACT_PREPEND = 2'd0;
    localparam logic [1:0] ACT_APPEND  = 2'd1;
    localparam logic [1:0] ACT_REMOVE  = 2'd2;
    localparam logic [1:0] ACT_INSERT  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } skq_state_t;
endpackage

### rtl/core/sorted_key_queue.sv
// ----------------------------------------------------------------------------
// sorted_key_queue
// Bounded queue of keyed entries held in ascending key order in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one action beat: s_action (prepend, append, remove
//   head, sorted insert), s_payload and s_sort_key. Every beat yields exactly
//   one result beat on m_valid/m_ready: m_out_payload and m_out_key for a
//   removed head (zero otherwise), m_was_empty and m_dropped flags.
//   Entries live in two single-port-write, one-read RAMs (key, payload),
//   with a registered read. Head is at the circular base pointer.
//   A remove from an empty queue, or a beat refused because the queue is
//   full, goes straight to its result; remove, prepend, append and an
//   insert into an empty queue read the RAM and then write. A sorted insert
//   reads entries one per cycle from the head up to the first key not below
//   the new key, then shifts the entries behind it one place back one per
//   cycle, from the tail down, and writes the new entry; no shift is needed
//   when the new key goes to the tail. The single read port sets this pace.
//   One beat is processed at a time; s_ready is low while busy. With m_ready
//   high the next beat is taken once m_valid has fallen.
//   If the receiver stalls, the result waits in the output register and the
//   block takes no new beat until it is taken.
//   Reset (aresetn low, synchronous) empties the queue; RAM contents are
//   not cleared, as no entry's value is used before it is written.
// ----------------------------------------------------------------------------
module sorted_key_queue
    import skq_pkg::*;
#(
    parameter int CAPACITY     = SKQ_CAPACITY,
    parameter int KEY_BITS     = SKQ_KEY_BITS,
    parameter int PAYLOAD_BITS = SKQ_PAYLOAD_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic [31:0]             s_payload,
    input  logic signed [15:0]      s_sort_key,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [31:0]             m_out_payload,
    output logic signed [15:0]      m_out_key,
    output logic                    m_was_empty,
    output logic                    m_dropped
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic signed [KEY_BITS-1:0] KMAX = {1'b0, {(KEY_BITS-1){1'b1}}};
    localparam logic signed [KEY_BITS-1:0] KMIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic signed [KEY_BITS-1:0] key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0]    pay_mem [CAPACITY];

    skq_state_t state_reg, state_next;
    logic [AW-1:0] base_reg, base_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] idx_reg, idx_next;      // logical position being worked
    logic [CW-1:0] pos_reg, pos_next;      // insert position
    logic [1:0]    act_reg, act_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;

    logic [PAYLOAD_BITS-1:0]    rd_pay;
    logic signed [KEY_BITS-1:0] rd_key;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic signed [KEY_BITS-1:0] wr_key;
    logic [PAYLOAD_BITS-1:0]    wr_pay;

    logic        mv_reg, mv_next;
    logic [31:0] mp_reg, mp_next;
    logic signed [15:0] mk_reg, mk_next;
    logic        me_reg, me_next, md_reg, md_next;

    // physical address of a logical position, modulo CAPACITY
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = {1'b0, (CW)'(b)} + {1'b0, p};
        if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    logic signed [KEY_BITS:0] kx;
    logic signed [KEY_BITS-1:0] skey_c;

    always_comb begin
        // sign-extend / saturate input key into KEY_BITS
        if (KEY_BITS >= 16) begin
            skey_c = KEY_BITS'(s_sort_key);
        end else if (s_sort_key > 16'(signed'(KMAX))) begin
            skey_c = KMAX;
        end else if (s_sort_key < 16'(signed'(KMIN))) begin
            skey_c = KMIN;
        end else begin
            skey_c = KEY_BITS'(s_sort_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        rd_key <= key_mem[rd_addr];
        rd_pay <= pay_mem[rd_addr];
    end

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;

    always_comb begin
        state_next = state_reg;
        base_next = base_reg;
        occ_next = occ_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        act_next = act_reg;
        pay_next = pay_reg;
        key_next = key_reg;
        mv_next = mv_reg && !m_ready;
        mp_next = mp_reg;
        mk_next = mk_reg;
        me_next = me_reg;
        md_next = md_reg;
        rd_addr = base_reg;
        wr_en = 1'b0;
        wr_addr = base_reg;
        wr_key = key_reg;
        wr_pay = pay_reg;
        kx = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    act_next = s_action;
                    pay_next = PAYLOAD_BITS'({32'd0, s_payload});
                    key_next = skey_c;
                    idx_next = '0;
                    mp_next = '0; mk_next = '0; me_next = 1'b0; md_next = 1'b0;
                    if (s_action == ACT_REMOVE) begin
                        rd_addr = base_reg;
                        if (occ_reg == '0) begin
                            me_next = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end else if (occ_reg == CAP_C) begin
                        md_next = 1'b1;
                        state_next = ST_DONE;
                    end else if (s_action == ACT_APPEND) begin
                        rd_addr = phys(base_reg, occ_reg - CW'(1));
                        state_next = ST_WRITE;
                    end else if (s_action == ACT_PREPEND) begin
                        rd_addr = base_reg;
                        state_next = ST_WRITE;
                    end else begin
                        rd_addr = base_reg;
                        state_next = (occ_reg == '0) ? ST_WRITE : ST_SCAN;
                        pos_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                // rd_key holds entry idx_reg
                if (rd_key >= key_reg) begin
                    pos_next = idx_reg;
                    idx_next = occ_reg;
                    rd_addr = phys(base_reg, occ_reg - CW'(1));
                    state_next = ST_SHIFT;
                end else if (idx_reg + CW'(1) == occ_reg) begin
                    pos_next = occ_reg;
                    state_next = ST_WRITE;
                end else begin
                    idx_next = idx_reg + CW'(1);
                    rd_addr = phys(base_reg, idx_reg + CW'(1));
                end
            end
            ST_SHIFT: begin
                // rd holds entry idx_reg-1; move it to idx_reg
                wr_en = 1'b1;
                wr_addr = phys(base_reg, idx_reg);
                wr_key = rd_key;
                wr_pay = rd_pay;
                idx_next = idx_reg - CW'(1);
                if (idx_reg - CW'(1) == pos_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    rd_addr = phys(base_reg, idx_reg - CW'(2));
                end
            end
            ST_WRITE: begin
                case (act_reg)
                    ACT_REMOVE: begin
                        mp_next = 32'({{(32){1'b0}}, rd_pay});
                        mk_next = 16'(rd_key);
                        base_next = phys(base_reg, CW'(1));
                        occ_next = occ_reg - CW'(1);
                    end
                    ACT_PREPEND: begin
                        kx = (KEY_BITS+1)'(rd_key) - (KEY_BITS+1)'(1);
                        wr_en = 1'b1;
                        wr_key = (occ_reg == '0) ? KEY_BITS'(1) :
                                 (kx < (KEY_BITS+1)'(KMIN)) ? KMIN : kx[KEY_BITS-1:0];
                        base_next = (base_reg == '0) ? AW'(CAPACITY - 1)
                                                     : base_reg - AW'(1);
                        wr_addr = base_next;
                        occ_next = occ_reg + CW'(1);
                    end
                    ACT_APPEND: begin
                        kx = (KEY_BITS+1)'(rd_key) + (KEY_BITS+1)'(1);
                        wr_en = 1'b1;
                        wr_key = (occ_reg == '0) ? KEY_BITS'(1) :
                                 (kx > (KEY_BITS+1)'(KMAX)) ? KMAX : kx[KEY_BITS-1:0];
                        wr_addr = phys(base_reg, occ_reg);
                        occ_next = occ_reg + CW'(1);
                    end
                    default: begin
                        wr_en = 1'b1;
                        wr_addr = phys(base_reg, pos_reg);
                        occ_next = occ_reg + CW'(1);
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE: begin
                mv_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            occ_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            base_reg  <= base_next;
            occ_reg   <= occ_next;
            mv_reg    <= mv_next;
        end
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        act_reg <= act_next;
        pay_reg <= pay_next;
        key_reg <= key_next;
        mp_reg  <= mp_next;
        mk_reg  <= mk_next;
        me_reg  <= me_next;
        md_reg  <= md_next;
    end

    assign m_valid       = mv_reg;
    assign m_out_payload = mp_reg;
    assign m_out_key     = mk_reg;
    assign m_was_empty   = me_reg;
    assign m_dropped     = md_reg;
endmodule
